// ----- sv/rlb_pkg.sv -----
// Shared types and the per-channel operand setup for the layer blend pipeline.
package rlb_pkg;

   typedef enum logic [3:0] {
      MODE_NORMAL   = 4'd0,
      MODE_MULTIPLY = 4'd1,
      MODE_ADDITIVE = 4'd2,
      MODE_BURN     = 4'd3,
      MODE_DODGE    = 4'd4,
      MODE_REFLECT  = 4'd5,
      MODE_GLOW     = 4'd6,
      MODE_OVERLAY  = 4'd7,
      MODE_DIFF     = 4'd8,
      MODE_NEGATION = 4'd9,
      MODE_LIGHTEN  = 4'd10,
      MODE_DARKEN   = 4'd11,
      MODE_SCREEN   = 4'd12,
      MODE_XOR      = 4'd13
   } mode_type;

   // How the last stage forms the channel value.
   typedef enum logic [1:0] {
      KIND_DIRECT = 2'd0,
      KIND_QUOT   = 2'd1,
      KIND_INV    = 2'd2
   } kind_type;

   localparam int DivBitsPerStage = 4;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] val;     // result for direct modes
      logic       sat;     // quotient is 256 or more
      logic [7:0] rem;     // partial remainder
      logic [7:0] num_lo;  // numerator bits not yet consumed
      logic [7:0] den;
      logic [7:0] quo;
   } chan_type;

   typedef struct packed {
      chan_type [2:0] ch;
      logic [7:0]     alpha;
   } stage_type;

   function automatic chan_type prep_chan(mode_type mode, logic [7:0] b, logic [7:0] l);
      logic [7:0]        ib;
      logic [7:0]        il;
      logic [7:0]        ma;
      logic [7:0]        mb;
      logic              dbl;
      logic [15:0]       prod;
      logic [15:0]       num;
      logic [8:0]        sum;
      logic signed [9:0] d;
      logic [9:0]        ad;
      chan_type          c;
      ib = ~b;
      il = ~l;
      ma = b;
      mb = l;
      dbl = 1'b0;
      c.kind = KIND_DIRECT;
      c.val = l;
      c.den = 8'd255;
      case (mode)
         MODE_MULTIPLY: c.kind = KIND_QUOT;
         MODE_ADDITIVE: begin
            sum = {1'b0, b} + {1'b0, l};
            c.val = sum[8] ? 8'd255 : sum[7:0];
         end
         MODE_BURN: begin
            if (l == 8'd0) begin
               c.val = 8'd0;
            end else begin
               c.kind = KIND_INV;
               ma = ib;
               mb = 8'd255;
               c.den = l;
            end
         end
         MODE_DODGE: begin
            if (l == 8'd255) begin
               c.val = 8'd255;
            end else begin
               c.kind = KIND_QUOT;
               mb = 8'd255;
               c.den = il;
            end
         end
         MODE_REFLECT: begin
            if (l == 8'd0) begin
               c.val = b;
            end else if (l == 8'd255) begin
               c.val = 8'd255;
            end else begin
               c.kind = KIND_QUOT;
               mb = b;
               c.den = il;
            end
         end
         MODE_GLOW: begin
            if (l == 8'd0) begin
               c.val = b;
            end else if (b == 8'd255) begin
               c.val = 8'd255;
            end else begin
               c.kind = KIND_QUOT;
               ma = l;
               c.den = ib;
            end
         end
         MODE_OVERLAY: begin
            dbl = 1'b1;
            if (l[7]) begin
               c.kind = KIND_INV;
               ma = ib;
               mb = il;
            end else begin
               c.kind = KIND_QUOT;
            end
         end
         MODE_DIFF:    c.val = (b > l) ? b - l : l - b;
         MODE_NEGATION: begin
            d = 10'sd255 - $signed({2'b00, b}) - $signed({2'b00, l});
            ad = d[9] ? 10'(-d) : 10'(d);
            c.val = 8'(10'd255 - ad);
         end
         MODE_LIGHTEN: c.val = (b > l) ? b : l;
         MODE_DARKEN:  c.val = (b < l) ? b : l;
         MODE_SCREEN: begin
            c.kind = KIND_INV;
            ma = ib;
            mb = il;
         end
         MODE_XOR:     c.val = b ^ l;
         default:      c.val = l;
      endcase
      prod = ma * mb;
      num = dbl ? {prod[14:0], 1'b0} : prod;
      c.sat = num[15:8] >= c.den;
      c.rem = num[15:8];
      c.num_lo = num[7:0];
      c.quo = 8'd0;
      return c;
   endfunction

endpackage

// ----- sv/rgb_layer_blend_unit.sv -----
// Top level of the RGB layer blend pipeline.
// Blends a base pixel with a blend pixel under the mode held in the csr
// register, one pixel per clock while rsp_tready is not holding a result.
// The req channel carries one pixel pair per transfer; the rsp channel
// returns one blended pixel per transfer, in the same order.
// A req transfer passes through four register stages before rsp_tvalid
// goes high: operand setup and product, two divider stages of four
// quotient bits each, and the output register. Throughput is one pixel
// per cycle while the output is not stalled; the divider sets the depth.
// The csr write takes effect for pixels accepted after the write edge and
// should be done while the pipeline is empty.
// Reset clears all stage valid bits and sets the mode to normal.
// When the receiver holds rsp_tready low with a result waiting, the whole
// pipeline freezes and req_tready drops in the same cycle; nothing is lost
// or repeated.
module rgb_layer_blend_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // base_r, base_g, base_b, blend_r, blend_g, blend_b, blend_a
   input  logic [55:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_r, out_g, out_b, out_a
   output logic [31:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);
   rlb_pkg::mode_type  mode_ff;
   logic               adv;
   logic               v1;
   logic               v2;
   logic               v3;
   rlb_pkg::stage_type s1;
   rlb_pkg::stage_type s2;
   rlb_pkg::stage_type s3;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= rlb_pkg::MODE_NORMAL;
      end else if (csr_wr_en) begin
         mode_ff <= rlb_pkg::mode_type'(csr_wr_data);
      end
   end

   assign adv = !(rsp_tvalid && !rsp_tready);
   assign req_tready = adv;

   rlb_prep_stage u_prep (
      .clock, .reset, .adv, .in_valid(req_tvalid), .mode(mode_ff),
      .in_data(req_tdata), .out_valid(v1), .out_stage(s1)
   );

   rlb_div_stage u_div_hi (
      .clock, .reset, .adv, .in_valid(v1), .in_stage(s1),
      .out_valid(v2), .out_stage(s2)
   );

   rlb_div_stage u_div_lo (
      .clock, .reset, .adv, .in_valid(v2), .in_stage(s2),
      .out_valid(v3), .out_stage(s3)
   );

   rlb_out_stage u_out (
      .clock, .reset, .adv, .in_valid(v3), .in_stage(s3),
      .out_valid(rsp_tvalid), .out_data(rsp_tdata)
   );
endmodule

// ----- sv/rlb_prep_stage.sv -----
// First pipeline stage: special cases, direct modes, numerator product and divisor.
module rlb_prep_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  rlb_pkg::mode_type mode,
   input  logic [55:0]       in_data,
   output logic              out_valid,
   output rlb_pkg::stage_type out_stage
);
   logic               valid_ff;
   rlb_pkg::stage_type stage_ff;
   rlb_pkg::stage_type stage_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         stage_in.ch[i] = rlb_pkg::prep_chan(mode, in_data[8*i +: 8], in_data[24 + 8*i +: 8]);
      end
      stage_in.alpha = in_data[55:48];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

// ----- sv/rlb_div_stage.sv -----
// Restoring divider stage: retires four quotient bits of every channel.
module rlb_div_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rlb_pkg::stage_type in_stage,
   output logic               out_valid,
   output rlb_pkg::stage_type out_stage
);
   logic               valid_ff;
   rlb_pkg::stage_type stage_ff;
   rlb_pkg::stage_type stage_in;

   always_comb begin
      logic [8:0] t;
      stage_in = in_stage;
      for (int i = 0; i < 3; i++) begin
         for (int s = 0; s < rlb_pkg::DivBitsPerStage; s++) begin
            t = {stage_in.ch[i].rem, stage_in.ch[i].num_lo[7]};
            stage_in.ch[i].num_lo = {stage_in.ch[i].num_lo[6:0], 1'b0};
            if (t >= {1'b0, stage_in.ch[i].den}) begin
               stage_in.ch[i].rem = 8'(t - {1'b0, stage_in.ch[i].den});
               stage_in.ch[i].quo = {stage_in.ch[i].quo[6:0], 1'b1};
            end else begin
               stage_in.ch[i].rem = t[7:0];
               stage_in.ch[i].quo = {stage_in.ch[i].quo[6:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

// ----- sv/rlb_out_stage.sv -----
// Output register: picks direct, saturated or inverted quotient per channel.
module rlb_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rlb_pkg::stage_type in_stage,
   output logic               out_valid,
   output logic [31:0]        out_data
);
   logic        valid_ff;
   logic [31:0] data_ff;
   logic [31:0] data_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         case (in_stage.ch[i].kind)
            rlb_pkg::KIND_QUOT:
               data_in[8*i +: 8] = in_stage.ch[i].sat ? 8'd255 : in_stage.ch[i].quo;
            rlb_pkg::KIND_INV:
               data_in[8*i +: 8] = in_stage.ch[i].sat ? 8'd0 : ~in_stage.ch[i].quo;
            default:
               data_in[8*i +: 8] = in_stage.ch[i].val;
         endcase
      end
      data_in[31:24] = in_stage.alpha;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
endmodule

// ----- sv/rlb_checker.sv -----
// Port-level checks for the blend pipeline, bound to the top level.
module rlb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      req_tready == !(rsp_tvalid && !rsp_tready))
      else $error("req_tready does not follow the output stall");

   // Advancing cycles with no transfer in, one per register stage, flush every stage.
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (!(req_tvalid && req_tready) && (!rsp_tvalid || rsp_tready)) [*4] |=> !rsp_tvalid)
      else $error("result appeared with no transfer in");
endmodule

bind rgb_layer_blend_unit rlb_checker u_rlb_checker (
   .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready, .rsp_tdata
);
